@@ sv/ssk_pkg.sv @@
// Shared types, sizes and codes for the sorted separator key table.
// Used by every module of the block but ssk_ram; depends on nothing else.
package ssk_pkg;

   // sizes of the node
   localparam int MAX_ENTRIES = 64;
   localparam int KEY_BITS    = 32;
   localparam int PAGE_BITS   = 32;
   localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
   localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
   localparam int SUM_BITS    = CNT_BITS + 1;
   localparam int CAP_BITS    = 7;
   localparam int LIM_BITS    = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;
   localparam int ENTRY_BITS  = KEY_BITS + PAGE_BITS;
   localparam int CMD_BITS    = 3;
   localparam int ERR_BITS    = 2;

   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;
   typedef logic [SUM_BITS-1:0]   sum_type;
   typedef logic [CAP_BITS-1:0]   cap_type;
   typedef logic [LIM_BITS-1:0]   lim_type;
   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [PAGE_BITS-1:0]  page_type;
   typedef logic [ENTRY_BITS-1:0] entry_type;
   typedef logic [CMD_BITS-1:0]   cmd_type;
   typedef logic [ERR_BITS-1:0]   err_type;

   // command codes
   localparam cmd_type CMD_SEARCH = 3'd0;
   localparam cmd_type CMD_INSERT = 3'd1;
   localparam cmd_type CMD_DELETE = 3'd2;
   localparam cmd_type CMD_READ   = 3'd3;
   localparam cmd_type CMD_WRITE  = 3'd4;

   // error codes
   localparam err_type ERR_OK    = 2'd0;
   localparam err_type ERR_FULL  = 2'd1;
   localparam err_type ERR_EMPTY = 2'd2;
   localparam err_type ERR_RANGE = 2'd3;

   localparam cap_type CAP_RESET = 7'd64;

   typedef struct packed {
      cmd_type  cmd;
      key_type  key;
      page_type child;
      idx_type  index;
   } req_type;

   typedef struct packed {
      idx_type  position;
      key_type  found_key;
      page_type found_child;
      cnt_type  entry_count;
      err_type  error;
   } rsp_type;

   typedef enum logic [2:0] {
      POS_HOLD,
      POS_ZERO,
      POS_ANS,
      POS_ANS_INC,
      POS_INDEX
   } pos_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_RAM,
      RES_REQ
   } res_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SRCH_ISSUE,
      ST_SRCH_STEP,
      ST_SHIFT_CHK,
      ST_SHIFT_WR,
      ST_WR_PUT,
      ST_DEL_CHK,
      ST_FIN_RD,
      ST_OUT_RAM,
      ST_OUT_REQ,
      ST_OUT_ZERO
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic        req_load;
      logic        err_load;
      err_type     err_val;
      logic        srch_init;
      logic        srch_issue;
      logic        srch_step;
      pos_sel_type pos_sel;
      logic        shift_up;
      logic        ptr_init;
      logic        shift_rd;
      logic        shift_wr;
      logic        place_wr;
      logic        pos_rd;
      cnt_op_type  cnt_op;
      logic        res_load;
      res_sel_type res_sel;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      cmd_type req_cmd;
      logic    count_zero;
      logic    table_full;
      logic    index_bad;
      logic    srch_more;
      logic    shift_up_more;
      logic    shift_dn_more;
      logic    pos_in_table;
      logic    rsp_free;
   } dp_status_type;

endpackage

@@ sv/sorted_separator_key_table.sv @@
// Top level of the sorted separator key table (one B+ tree internal node).
// Depends on ssk_pkg, ssk_ctrl and ssk_dpath.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   ssk_pkg::req_type (cmd, key, child, index)
//   rsp      out  rsp_valid/rsp_stall   ssk_pkg::rsp_type (position .. error)
//   csr      in   csr_wr_en             capacity, 7 bits
//
// A search makes p <= ceil(log2(count)) probes; insert and delete then move m entries,
// and a delete that leaves an entry at the position reads it back for the result.
// Read and write skip the search; a refused request goes straight to the result.
// The next request is taken in the cycle after the result is loaded.
// Synchronous reset clears the count, sets capacity to 64 and empties the
// result register; the entry RAM keeps its contents and is not swept.
// A result waits in its register under rsp_stall while the next request is taken.
module sorted_separator_key_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ssk_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ssk_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  ssk_pkg::cap_type csr_wr_data
);

   ssk_pkg::dp_cmd_type    dp_cmd;
   ssk_pkg::dp_status_type dp_status;

   ssk_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (dp_status),
      .dp_cmd   (dp_cmd)
   );

   ssk_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .dp_cmd     (dp_cmd),
      .status     (dp_status)
   );

endmodule

@@ sv/ssk_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No package dependencies; used for the entry store of the table.
module ssk_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, hold between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/ssk_ctrl.sv @@
// Sequencer of the key table: decodes a request and steps the datapath
// through search, shift, place and result. Depends on ssk_pkg.
module ssk_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ssk_pkg::dp_status_type status,
   output ssk_pkg::dp_cmd_type    dp_cmd
);

   ssk_pkg::state_type state_ff;
   ssk_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssk_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in         = state_ff;
      req_stall        = 1'b1;
      dp_cmd           = '0;
      dp_cmd.err_val   = ssk_pkg::ERR_OK;
      dp_cmd.pos_sel   = ssk_pkg::POS_HOLD;
      dp_cmd.cnt_op    = ssk_pkg::CNT_HOLD;
      dp_cmd.res_sel   = ssk_pkg::RES_ZERO;
      dp_cmd.shift_up  = (status.req_cmd == ssk_pkg::CMD_INSERT);

      case (state_ff)
         ssk_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               dp_cmd.req_load = 1'b1;
               state_in        = ssk_pkg::ST_DECODE;
            end
         end

         // pick the path and the error code
         ssk_pkg::ST_DECODE: begin
            dp_cmd.err_load = 1'b1;
            case (status.req_cmd)
               ssk_pkg::CMD_SEARCH, ssk_pkg::CMD_DELETE: begin
                  if (status.count_zero) begin
                     dp_cmd.err_val = ssk_pkg::ERR_EMPTY;
                     dp_cmd.pos_sel = ssk_pkg::POS_ZERO;
                     state_in       = ssk_pkg::ST_OUT_ZERO;
                  end else begin
                     dp_cmd.srch_init = 1'b1;
                     state_in         = ssk_pkg::ST_SRCH_ISSUE;
                  end
               end
               ssk_pkg::CMD_INSERT: begin
                  if (status.table_full) begin
                     dp_cmd.err_val = ssk_pkg::ERR_FULL;
                     dp_cmd.pos_sel = ssk_pkg::POS_ZERO;
                     state_in       = ssk_pkg::ST_OUT_ZERO;
                  end else begin
                     dp_cmd.srch_init = 1'b1;
                     state_in         = ssk_pkg::ST_SRCH_ISSUE;
                  end
               end
               ssk_pkg::CMD_READ: begin
                  dp_cmd.pos_sel = ssk_pkg::POS_INDEX;
                  if (status.index_bad) begin
                     dp_cmd.err_val = ssk_pkg::ERR_RANGE;
                     state_in       = ssk_pkg::ST_OUT_ZERO;
                  end else begin
                     state_in = ssk_pkg::ST_FIN_RD;
                  end
               end
               ssk_pkg::CMD_WRITE: begin
                  dp_cmd.pos_sel = ssk_pkg::POS_INDEX;
                  if (status.index_bad) begin
                     dp_cmd.err_val = ssk_pkg::ERR_RANGE;
                     state_in       = ssk_pkg::ST_OUT_ZERO;
                  end else begin
                     state_in = ssk_pkg::ST_WR_PUT;
                  end
               end
               default: begin
                  dp_cmd.pos_sel = ssk_pkg::POS_INDEX;
                  state_in       = ssk_pkg::ST_OUT_ZERO;
               end
            endcase
         end

         // issue the next probe or finish the search
         ssk_pkg::ST_SRCH_ISSUE: begin
            if (status.srch_more) begin
               dp_cmd.srch_issue = 1'b1;
               state_in          = ssk_pkg::ST_SRCH_STEP;
            end else begin
               case (status.req_cmd)
                  ssk_pkg::CMD_INSERT: begin
                     dp_cmd.pos_sel  = ssk_pkg::POS_ANS_INC;
                     dp_cmd.ptr_init = 1'b1;
                     state_in        = ssk_pkg::ST_SHIFT_CHK;
                  end
                  ssk_pkg::CMD_DELETE: begin
                     dp_cmd.pos_sel  = ssk_pkg::POS_ANS;
                     dp_cmd.ptr_init = 1'b1;
                     state_in        = ssk_pkg::ST_SHIFT_CHK;
                  end
                  default: begin
                     dp_cmd.pos_sel = ssk_pkg::POS_ANS;
                     state_in       = ssk_pkg::ST_FIN_RD;
                  end
               endcase
            end
         end

         ssk_pkg::ST_SRCH_STEP: begin
            dp_cmd.srch_step = 1'b1;
            state_in         = ssk_pkg::ST_SRCH_ISSUE;
         end

         // move one entry, or place the new entry (insert) or decrement the count (delete)
         ssk_pkg::ST_SHIFT_CHK: begin
            if (dp_cmd.shift_up ? status.shift_up_more : status.shift_dn_more) begin
               dp_cmd.shift_rd = 1'b1;
               state_in        = ssk_pkg::ST_SHIFT_WR;
            end else if (dp_cmd.shift_up) begin
               dp_cmd.place_wr = 1'b1;
               dp_cmd.cnt_op   = ssk_pkg::CNT_INC;
               state_in        = ssk_pkg::ST_OUT_REQ;
            end else begin
               dp_cmd.cnt_op = ssk_pkg::CNT_DEC;
               state_in      = ssk_pkg::ST_DEL_CHK;
            end
         end

         ssk_pkg::ST_SHIFT_WR: begin
            dp_cmd.shift_wr = 1'b1;
            state_in        = ssk_pkg::ST_SHIFT_CHK;
         end

         ssk_pkg::ST_WR_PUT: begin
            dp_cmd.place_wr = 1'b1;
            state_in        = ssk_pkg::ST_OUT_REQ;
         end

         // after a delete the position may lie past the table
         ssk_pkg::ST_DEL_CHK: begin
            if (status.pos_in_table) begin
               state_in = ssk_pkg::ST_FIN_RD;
            end else begin
               state_in = ssk_pkg::ST_OUT_ZERO;
            end
         end

         ssk_pkg::ST_FIN_RD: begin
            dp_cmd.pos_rd = 1'b1;
            state_in      = ssk_pkg::ST_OUT_RAM;
         end

         // hold until the result register can take the transfer
         ssk_pkg::ST_OUT_RAM: begin
            dp_cmd.res_sel = ssk_pkg::RES_RAM;
            if (status.rsp_free) begin
               dp_cmd.res_load = 1'b1;
               state_in        = ssk_pkg::ST_IDLE;
            end
         end

         ssk_pkg::ST_OUT_REQ: begin
            dp_cmd.res_sel = ssk_pkg::RES_REQ;
            if (status.rsp_free) begin
               dp_cmd.res_load = 1'b1;
               state_in        = ssk_pkg::ST_IDLE;
            end
         end

         ssk_pkg::ST_OUT_ZERO: begin
            dp_cmd.res_sel = ssk_pkg::RES_ZERO;
            if (status.rsp_free) begin
               dp_cmd.res_load = 1'b1;
               state_in        = ssk_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ssk_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ sv/ssk_dpath.sv @@
// Datapath of the key table: entry RAM, count and capacity registers,
// search bounds, shift pointer and result register. Depends on ssk_pkg, ssk_ram.
module ssk_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  ssk_pkg::req_type       req_data,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output ssk_pkg::rsp_type       rsp_data,
   input  logic                   csr_wr_en,
   input  ssk_pkg::cap_type       csr_wr_data,
   input  ssk_pkg::dp_cmd_type    dp_cmd,
   output ssk_pkg::dp_status_type status
);

   ssk_pkg::req_type   req_ff;
   ssk_pkg::cap_type   capacity_ff;
   ssk_pkg::cnt_type   count_ff;
   ssk_pkg::cnt_type   count_in;
   ssk_pkg::err_type   err_ff;
   ssk_pkg::cnt_type   lo_ff;
   ssk_pkg::cnt_type   lo_in;
   ssk_pkg::cnt_type   hi_ff;
   ssk_pkg::cnt_type   hi_in;
   ssk_pkg::idx_type   ans_ff;
   ssk_pkg::idx_type   ans_in;
   ssk_pkg::idx_type   mid_ff;
   ssk_pkg::idx_type   mid_in;
   ssk_pkg::idx_type   pos_ff;
   ssk_pkg::idx_type   pos_in;
   ssk_pkg::idx_type   ptr_ff;
   ssk_pkg::idx_type   ptr_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   ssk_pkg::rsp_type   rsp_data_ff;
   ssk_pkg::rsp_type   rsp_data_in;

   ssk_pkg::sum_type   bound_sum;
   ssk_pkg::key_type   probe_key;
   logic               ram_wr_en;
   ssk_pkg::idx_type   ram_wr_addr;
   ssk_pkg::entry_type ram_wr_data;
   logic               ram_rd_en;
   ssk_pkg::idx_type   ram_rd_addr;
   ssk_pkg::entry_type ram_rd_data;

   // entry store: key in the upper part, child page in the lower
   ssk_ram #(
      .WIDTH(ssk_pkg::ENTRY_BITS),
      .DEPTH(ssk_pkg::MAX_ENTRIES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign probe_key = ram_rd_data[ssk_pkg::ENTRY_BITS-1 -: ssk_pkg::KEY_BITS];
   assign bound_sum = ssk_pkg::sum_type'(lo_ff) + ssk_pkg::sum_type'(hi_ff);

   // RAM port steering
   always_comb begin
      ram_wr_en   = dp_cmd.shift_wr | dp_cmd.place_wr;
      ram_wr_addr = dp_cmd.shift_wr ? ptr_ff : pos_ff;
      ram_wr_data = dp_cmd.shift_wr ? ram_rd_data : {req_ff.key, req_ff.child};
      ram_rd_en   = dp_cmd.srch_issue | dp_cmd.shift_rd | dp_cmd.pos_rd;
      if (dp_cmd.srch_issue) begin
         ram_rd_addr = mid_in;
      end else if (dp_cmd.shift_rd) begin
         ram_rd_addr = dp_cmd.shift_up ? (ptr_ff - ssk_pkg::idx_type'(1))
                                       : (ptr_ff + ssk_pkg::idx_type'(1));
      end else begin
         ram_rd_addr = pos_ff;
      end
   end

   // search bounds and probe
   always_comb begin
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      ans_in = ans_ff;
      mid_in = ssk_pkg::idx_type'(bound_sum >> 1);
      if (dp_cmd.srch_init) begin
         lo_in  = ssk_pkg::cnt_type'(1);
         hi_in  = count_ff;
         ans_in = '0;
      end else if (dp_cmd.srch_step) begin
         if (req_ff.key >= probe_key) begin
            ans_in = mid_ff;
            lo_in  = ssk_pkg::cnt_type'(mid_ff) + ssk_pkg::cnt_type'(1);
         end else begin
            hi_in = ssk_pkg::cnt_type'(mid_ff);
         end
      end
   end

   // position, shift pointer and entry count
   always_comb begin
      case (dp_cmd.pos_sel)
         ssk_pkg::POS_ZERO:    pos_in = '0;
         ssk_pkg::POS_ANS:     pos_in = ans_ff;
         ssk_pkg::POS_ANS_INC: pos_in = (count_ff == '0) ? '0
                                        : (ans_ff + ssk_pkg::idx_type'(1));
         ssk_pkg::POS_INDEX:   pos_in = req_ff.index;
         default:              pos_in = pos_ff;
      endcase

      ptr_in = ptr_ff;
      if (dp_cmd.ptr_init) begin
         ptr_in = dp_cmd.shift_up ? ssk_pkg::idx_type'(count_ff) : ans_ff;
      end else if (dp_cmd.shift_wr) begin
         ptr_in = dp_cmd.shift_up ? (ptr_ff - ssk_pkg::idx_type'(1))
                                  : (ptr_ff + ssk_pkg::idx_type'(1));
      end

      case (dp_cmd.cnt_op)
         ssk_pkg::CNT_INC: count_in = count_ff + ssk_pkg::cnt_type'(1);
         ssk_pkg::CNT_DEC: count_in = count_ff - ssk_pkg::cnt_type'(1);
         default:          count_in = count_ff;
      endcase
   end

   // result register: load on command, drop once the transfer is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (dp_cmd.res_load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.position    = pos_ff;
         rsp_data_in.entry_count = count_ff;
         rsp_data_in.error       = err_ff;
         case (dp_cmd.res_sel)
            ssk_pkg::RES_RAM: begin
               rsp_data_in.found_key   = probe_key;
               rsp_data_in.found_child = ram_rd_data[ssk_pkg::PAGE_BITS-1:0];
            end
            ssk_pkg::RES_REQ: begin
               rsp_data_in.found_key   = req_ff.key;
               rsp_data_in.found_child = req_ff.child;
            end
            default: begin
               rsp_data_in.found_key   = '0;
               rsp_data_in.found_child = '0;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         capacity_ff  <= ssk_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (dp_cmd.req_load) begin
         req_ff <= req_data;
      end
      if (dp_cmd.err_load) begin
         err_ff <= dp_cmd.err_val;
      end
      if (dp_cmd.srch_issue) begin
         mid_ff <= mid_in;
      end
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      ans_ff      <= ans_in;
      pos_ff      <= pos_in;
      ptr_ff      <= ptr_in;
      rsp_data_ff <= rsp_data_in;
   end

   // status back to the sequencer
   always_comb begin
      status.req_cmd       = req_ff.cmd;
      status.count_zero    = (count_ff == '0);
      status.table_full    = (ssk_pkg::lim_type'(count_ff) >= ssk_pkg::lim_type'(capacity_ff))
                          || (ssk_pkg::lim_type'(count_ff)
                              >= ssk_pkg::lim_type'(ssk_pkg::MAX_ENTRIES));
      status.index_bad     = (ssk_pkg::cnt_type'(req_ff.index) >= count_ff);
      status.srch_more     = (lo_ff < hi_ff);
      status.shift_up_more = (ptr_ff > pos_ff);
      status.shift_dn_more = ((ssk_pkg::cnt_type'(ptr_ff) + ssk_pkg::cnt_type'(1)) < count_ff);
      status.pos_in_table  = (ssk_pkg::cnt_type'(pos_ff) < count_ff);
      status.rsp_free      = ~rsp_valid_ff | ~rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
